// File: rtl/core/tsop_pkg.sv
// tsop_pkg: shared constants, codes and types of the transmit slot ownership pool.
// No dependencies; compiled first.
`default_nettype none

package tsop_pkg;

	localparam int NUM_SLOTS_DEF  = 8;
	localparam int SLOT_BYTES_DEF = 256;

	localparam int OP_W      = 2;
	localparam int SEL_W     = 3;
	localparam int LEN_W     = 9;
	localparam int ADDR_W    = 8;
	localparam int PEND_W    = 4;
	localparam int LEN_CMP_W = 13;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_SUBMIT  = 2'd1,
		OP_TAKE    = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OWN_FREE   = 2'd0,
		OWN_HELD   = 2'd1,
		OWN_READY  = 2'd2,
		OWN_FLIGHT = 2'd3
	} own_t;

	typedef struct packed {
		op_t               op;
		logic [SEL_W-1:0]  sel;
		logic              sel_ok;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr;
	} dec_t;

endpackage

`default_nettype wire

// File: rtl/core/tsop_if.sv
// tsop_req_if / tsop_rsp_if: valid/ready channels carrying one op word and one result word.
// Depends on tsop_pkg for field widths.
`default_nettype none

interface tsop_req_if;
	logic                         valid;
	logic                         ready;
	logic [tsop_pkg::OP_W-1:0]    op;
	logic [tsop_pkg::SEL_W-1:0]   slot_sel;
	logic [tsop_pkg::LEN_W-1:0]   length;
	logic [tsop_pkg::ADDR_W-1:0]  dest_addr;

	modport source (output valid, op, slot_sel, length, dest_addr, input ready);
	modport sink   (input valid, op, slot_sel, length, dest_addr, output ready);
endinterface

interface tsop_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         status;
	logic [tsop_pkg::SEL_W-1:0]   slot_index;
	logic [tsop_pkg::LEN_W-1:0]   max_bytes;
	logic [tsop_pkg::LEN_W-1:0]   send_length;
	logic [tsop_pkg::ADDR_W-1:0]  send_addr;
	logic [tsop_pkg::PEND_W-1:0]  pending;

	modport source (output valid, status, slot_index, max_bytes, send_length, send_addr,
		pending, input ready);
	modport sink   (input valid, status, slot_index, max_bytes, send_length, send_addr,
		pending, output ready);
endinterface

`default_nettype wire

// File: rtl/core/tsop_ram.sv
// tsop_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic                                 re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tsop_front.sv
// tsop_front: accepts op words, clamps the byte count, checks the slot select,
// and queues decoded words for the back end. Depends on tsop_pkg, tsop_if.
`default_nettype none

module tsop_front #(
	parameter int NUM_SLOTS  = tsop_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = tsop_pkg::SLOT_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tsop_req_if.sink        req,
	output logic            q_valid,
	output tsop_pkg::dec_t  q_data,
	input  wire logic       q_pop
);

	tsop_pkg::dec_t                    mem_q [tsop_pkg::Q_DEPTH];
	tsop_pkg::dec_t                    dec;
	logic [tsop_pkg::Q_PTR_W-1:0]      wr_ptr_q;
	logic [tsop_pkg::Q_PTR_W-1:0]      rd_ptr_q;
	logic [tsop_pkg::Q_CNT_W-1:0]      cnt_q;
	logic                              push;

	assign req.ready = (cnt_q != tsop_pkg::Q_CNT_W'(tsop_pkg::Q_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_data    = mem_q[rd_ptr_q];

	always_comb begin
		dec.op     = tsop_pkg::op_t'(req.op);
		dec.sel    = req.slot_sel;
		dec.sel_ok = (int'(req.slot_sel) < NUM_SLOTS);
		dec.addr   = req.dest_addr;
		if (tsop_pkg::LEN_CMP_W'(req.length) > tsop_pkg::LEN_CMP_W'(SLOT_BYTES)) begin
			dec.len = tsop_pkg::LEN_W'(SLOT_BYTES);
		end else begin
			dec.len = req.length;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/tsop_back.sv
// tsop_back: owner-state table, priority search, pending count, slot RAM and
// the result register. Depends on tsop_pkg, tsop_if, tsop_ram.
`default_nettype none

module tsop_back #(
	parameter int NUM_SLOTS  = tsop_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = tsop_pkg::SLOT_BYTES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	input  wire tsop_pkg::dec_t  q_data,
	output logic                 q_pop,
	tsop_rsp_if.source           rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int RAM_W = tsop_pkg::LEN_W + tsop_pkg::ADDR_W;

	tsop_pkg::own_t                owner_q [NUM_SLOTS];
	tsop_pkg::own_t                owner_d [NUM_SLOTS];
	logic [CNT_W-1:0]              pend_q;
	logic [CNT_W-1:0]              pend_d;
	logic                          rsp_valid_q;
	logic                          status_q;
	logic [tsop_pkg::SEL_W-1:0]    idx_q;
	logic [tsop_pkg::LEN_W-1:0]    maxb_q;
	logic                          take_q;

	logic                          fire;
	logic                          found_free, found_ready, found_flight;
	logic [IDX_W-1:0]              free_idx, ready_idx, flight_idx;
	logic [IDX_W-1:0]              sel_idx;
	logic                          st_d;
	logic [IDX_W-1:0]              idx_d;
	logic [tsop_pkg::LEN_W-1:0]    maxb_d;
	logic                          take_d;
	logic                          we;
	logic                          re;
	logic [RAM_W-1:0]              rdata;

	assign fire    = q_valid && (!rsp_valid_q || rsp.ready);
	assign q_pop   = fire;
	assign sel_idx = IDX_W'(q_data.sel);

	// lowest slot wins
	always_comb begin
		found_free   = 1'b0;
		found_ready  = 1'b0;
		found_flight = 1'b0;
		free_idx     = '0;
		ready_idx    = '0;
		flight_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (owner_q[i] == tsop_pkg::OWN_FREE) begin
				found_free = 1'b1;
				free_idx   = IDX_W'(i);
			end
			if (owner_q[i] == tsop_pkg::OWN_READY) begin
				found_ready = 1'b1;
				ready_idx   = IDX_W'(i);
			end
			if (owner_q[i] == tsop_pkg::OWN_FLIGHT) begin
				found_flight = 1'b1;
				flight_idx   = IDX_W'(i);
			end
		end
	end

	always_comb begin
		owner_d = owner_q;
		pend_d  = pend_q;
		st_d    = 1'b1;
		idx_d   = '0;
		maxb_d  = '0;
		take_d  = 1'b0;
		we      = 1'b0;
		re      = 1'b0;
		unique case (q_data.op)
			tsop_pkg::OP_ALLOC: begin
				if (found_free) begin
					owner_d[free_idx] = tsop_pkg::OWN_HELD;
					st_d              = 1'b0;
					idx_d             = free_idx;
					maxb_d            = tsop_pkg::LEN_W'(SLOT_BYTES);
				end
			end
			tsop_pkg::OP_SUBMIT: begin
				if (q_data.sel_ok && owner_q[sel_idx] == tsop_pkg::OWN_HELD) begin
					owner_d[sel_idx] = tsop_pkg::OWN_READY;
					pend_d           = CNT_W'(pend_q + 1'b1);
					st_d             = 1'b0;
					we               = fire;
				end
			end
			tsop_pkg::OP_TAKE: begin
				if (found_ready) begin
					owner_d[ready_idx] = tsop_pkg::OWN_FLIGHT;
					st_d               = 1'b0;
					idx_d              = ready_idx;
					take_d             = 1'b1;
					re                 = fire;
				end
			end
			tsop_pkg::OP_RELEASE: begin
				if (found_flight) begin
					owner_d[flight_idx] = tsop_pkg::OWN_FREE;
					st_d                = 1'b0;
					if (pend_q != '0) begin
						pend_d = CNT_W'(pend_q - 1'b1);
					end
				end
			end
			default: begin
				st_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				owner_q[i] <= tsop_pkg::OWN_FREE;
			end
			pend_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				owner_q     <= owner_d;
				pend_q      <= pend_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= st_d;
			idx_q    <= tsop_pkg::SEL_W'(idx_d);
			maxb_q   <= maxb_d;
			take_q   <= take_d;
		end
	end

	// {length, addr} per slot; read data holds while the result stalls
	tsop_ram #(
		.WIDTH(RAM_W),
		.DEPTH(NUM_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (we),
		.waddr (sel_idx),
		.wdata ({q_data.len, q_data.addr}),
		.re    (re),
		.raddr (ready_idx),
		.rdata (rdata)
	);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.slot_index  = idx_q;
	assign rsp.max_bytes   = maxb_q;
	assign rsp.send_length = take_q ? rdata[RAM_W-1:tsop_pkg::ADDR_W] : '0;
	assign rsp.send_addr   = take_q ? rdata[tsop_pkg::ADDR_W-1:0] : '0;
	assign rsp.pending     = tsop_pkg::PEND_W'(pend_q);

endmodule

`default_nettype wire

// File: rtl/core/tx_slot_ownership_pool_unit.sv
// tx_slot_ownership_pool_unit: top level of the transmit slot ownership pool.
// Depends on tsop_pkg, tsop_if, tsop_front, tsop_back (and tsop_ram below it).
//
//   channel  dir  word                                           handshake
//   req      in   op, slot_sel, length, dest_addr               valid/ready
//   rsp      out  status, slot_index, max_bytes, send_length,   valid/ready
//                 send_addr, pending
//
// One op per cycle unless rsp stalls; a taken op is queued, then executed.
// The rate is set by the combinational priority search over the owner states.
// Reset marks every slot free and clears the pending count; no clearing pass.
// A two-word queue separates intake from execution, so req keeps flowing while
// a result waits on rsp; req.ready drops only when the queue is full.
`default_nettype none

module tx_slot_ownership_pool_unit #(
	parameter int NUM_SLOTS  = tsop_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES = tsop_pkg::SLOT_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsop_req_if.sink   req,
	tsop_rsp_if.source rsp
);

	logic           q_valid;
	logic           q_pop;
	tsop_pkg::dec_t q_data;

	tsop_front #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	tsop_back #(
		.NUM_SLOTS  (NUM_SLOTS),
		.SLOT_BYTES (SLOT_BYTES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/core/tsop_checker.sv
// tsop_checker: port-level assertions for tx_slot_ownership_pool_unit, bound to it.
// Depends on tsop_pkg and the top level's ports.
`default_nettype none

module tsop_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic                         rsp_status,
	input wire logic [tsop_pkg::SEL_W-1:0]   rsp_slot_index,
	input wire logic [tsop_pkg::LEN_W-1:0]   rsp_max_bytes,
	input wire logic [tsop_pkg::LEN_W-1:0]   rsp_send_length,
	input wire logic [tsop_pkg::ADDR_W-1:0]  rsp_send_addr,
	input wire logic [tsop_pkg::PEND_W-1:0]  rsp_pending
);

	logic [2:0]                      outst_q;
	logic [tsop_pkg::PEND_W-1:0]     last_pend_q;
	logic [tsop_pkg::PEND_W-1:0]     pend_diff;
	logic                            in_acc;
	logic                            out_acc;

	assign in_acc    = req_valid && req_ready;
	assign out_acc   = rsp_valid && rsp_ready;
	assign pend_diff = rsp_pending - last_pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outst_q     <= '0;
			last_pend_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				outst_q <= outst_q + 1'b1;
			end else if (!in_acc && out_acc) begin
				outst_q <= outst_q - 1'b1;
			end
			if (out_acc) begin
				last_pend_q <= rsp_pending;
			end
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot_index)
			&& $stable(rsp_max_bytes) && $stable(rsp_send_length)
			&& $stable(rsp_send_addr) && $stable(rsp_pending))
		else $error("rsp word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outst_q != '0)
		else $error("rsp word without a pending req word");

	a_pend_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (pend_diff == '0) || (pend_diff == 4'd1) || (pend_diff == 4'hF))
		else $error("pending moved by more than one between words");

endmodule

bind tx_slot_ownership_pool_unit tsop_checker u_tsop_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot_index  (rsp.slot_index),
	.rsp_max_bytes   (rsp.max_bytes),
	.rsp_send_length (rsp.send_length),
	.rsp_send_addr   (rsp.send_addr),
	.rsp_pending     (rsp.pending)
);

`default_nettype wire
